@@ sv/sorted_cumulative_distribution_macros.svh @@
// Assertion helpers for the sorted cumulative distribution block.
`ifndef SORTED_CUMULATIVE_DISTRIBUTION_MACROS_SVH
`define SORTED_CUMULATIVE_DISTRIBUTION_MACROS_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define SCD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("scd check failed");

// Next-cycle implication, sampled on aclk, off during reset.
`define SCD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("scd check failed");

`endif

@@ sv/scd_pkg.sv @@
`default_nettype none

package scd_pkg;

    localparam int SAMPLE_W       = 32;
    localparam int RANK_W         = 7;
    localparam int FRAC_W         = 17;
    localparam int MAX_POINTS_DEF = 64;
    localparam int M_DATA_W       = SAMPLE_W + RANK_W + FRAC_W;  // 56, whole bytes
    localparam int DIV_IDX_W      = $clog2(FRAC_W);
    localparam int DIV_MSB        = FRAC_W - 1;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_EMIT
    } state_t;

    // Broadcast control for the cell row
    typedef struct packed {
        logic    ins;
        logic    shift;
        sample_t sample;
    } cell_ctrl_t;

    // What one cell shows its neighbours
    typedef struct packed {
        logic    valid;
        logic    take;
        sample_t value;
    } cell_link_t;

    typedef struct packed {
        logic start;
        logic step;
    } frac_ctrl_t;

endpackage

`default_nettype wire

@@ sv/sorted_cumulative_distribution.sv @@
// Sorted cumulative distribution of signed Q16.16 samples.
// Input stream (s_): one sample per transfer, s_tlast marks the final sample
// of a data set. Samples go straight into a row of MAX_POINTS insertion
// cells that keeps them in ascending order; loading takes one transfer per
// cycle. Samples arriving with the row full are dropped and flagged.
// After the final sample the block works out 65536/count by a bit-serial
// divider, forms the first fraction and starts the emission. Results then
// stream out of the head of the row at one per cycle while m_tready does
// not stall them, one per stored sample, with rank, rank/count in Q1.16,
// tlast on the largest and tuser set if samples were dropped. s_tready is
// low from the final sample until the last result has been loaded into
// the output register.
// A stall on m_tready holds the output register and freezes the row.
// Reset (aresetn low, synchronous) empties the row and clears the flags.
`default_nettype none

module sorted_cumulative_distribution #(
    parameter int MAX_POINTS = scd_pkg::MAX_POINTS_DEF
) (
    input  wire                             aclk,
    input  wire                             aresetn,
    // s_tdata: sample[31:0]
    input  wire  [scd_pkg::SAMPLE_W-1:0]    s_tdata,
    input  wire                             s_tlast,   // last_sample
    input  wire                             s_tvalid,
    output logic                            s_tready,
    // m_tdata: value[31:0], rank[38:32], fraction[55:39]
    output logic [scd_pkg::M_DATA_W-1:0]    m_tdata,
    output logic [0:0]                      m_tuser,   // overflow[0]
    output logic                            m_tlast,   // last_result
    output logic                            m_tvalid,
    input  wire                             m_tready
);

    localparam int RW = scd_pkg::RANK_W;
    localparam int FW = scd_pkg::FRAC_W;

    localparam scd_pkg::cell_link_t LINK_EMPTY = '{valid: 1'b0, take: 1'b0, value: '0};

    scd_pkg::state_t     state_reg, state_next;
    logic [RW-1:0]       count_reg, count_next;
    logic [RW-1:0]       rank_reg, rank_next;
    logic                dropped_reg, dropped_next;
    logic                m_valid_reg, m_valid_next;
    logic [scd_pkg::M_DATA_W-1:0] m_data_reg;
    logic                m_last_reg, m_ovf_reg;

    scd_pkg::cell_ctrl_t cell_ctrl;
    scd_pkg::cell_link_t links [MAX_POINTS];
    scd_pkg::frac_ctrl_t frac_ctrl;
    logic                frac_busy;
    logic [FW-1:0]       frac;
    logic                full;
    logic                ld;
    logic                final_one;

    // Row of insertion cells; cell 0 holds the smallest sample
    for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
        scd_pkg::cell_link_t prev_link, next_link;
        if (i == 0) begin : g_head
            assign prev_link = LINK_EMPTY;
        end else begin : g_mid
            assign prev_link = links[i-1];
        end
        if (i == MAX_POINTS - 1) begin : g_tail
            assign next_link = LINK_EMPTY;
        end else begin : g_body
            assign next_link = links[i+1];
        end
        scd_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (cell_ctrl),
            .prev    (prev_link),
            .next    (next_link),
            .own     (links[i])
        );
    end

    scd_frac u_frac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (frac_ctrl),
        .n       (count_next),
        .busy    (frac_busy),
        .frac    (frac)
    );

    assign full      = links[MAX_POINTS-1].valid;
    assign final_one = rank_reg == count_reg;

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        rank_next       = rank_reg;
        dropped_next    = dropped_reg;
        s_tready        = 1'b0;
        ld              = 1'b0;
        cell_ctrl.ins   = 1'b0;
        cell_ctrl.shift = 1'b0;
        cell_ctrl.sample = s_tdata;
        frac_ctrl.start = 1'b0;
        frac_ctrl.step  = 1'b0;
        unique case (state_reg)
            scd_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cell_ctrl.ins = !full;
                    dropped_next  = dropped_reg || full;
                    count_next    = count_reg + RW'(!full);
                    if (s_tlast) begin
                        if (count_next != '0) begin
                            frac_ctrl.start = 1'b1;
                            state_next      = scd_pkg::ST_DIVIDE;
                        end else begin
                            dropped_next = 1'b0;
                        end
                    end
                end
            end
            scd_pkg::ST_DIVIDE: begin
                if (!frac_busy) begin
                    state_next = scd_pkg::ST_EMIT;
                end
            end
            scd_pkg::ST_EMIT: begin
                ld = !m_valid_reg || m_tready;
                if (ld) begin
                    cell_ctrl.shift = 1'b1;
                    frac_ctrl.step  = 1'b1;
                    rank_next       = rank_reg + RW'(1);
                    if (final_one) begin
                        state_next   = scd_pkg::ST_IDLE;
                        count_next   = '0;
                        rank_next    = RW'(1);
                        dropped_next = 1'b0;
                    end
                end
            end
            default: begin
                state_next = scd_pkg::ST_IDLE;
            end
        endcase
    end

    // output register: loads from the head cell, holds while stalled
    always_comb begin
        if (ld) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= scd_pkg::ST_IDLE;
            count_reg   <= '0;
            rank_reg    <= RW'(1);
            dropped_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            rank_reg    <= rank_next;
            dropped_reg <= dropped_next;
            m_valid_reg <= m_valid_next;
        end
        if (ld) begin
            m_data_reg <= {frac, rank_reg, links[0].value};
            m_last_reg <= final_one;
            m_ovf_reg  <= dropped_reg;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tlast    = m_last_reg;
    assign m_tuser[0] = m_ovf_reg;

endmodule

`default_nettype wire

@@ sv/scd_cell.sv @@
`default_nettype none

module scd_cell (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  scd_pkg::cell_ctrl_t  ctrl,
    input  scd_pkg::cell_link_t  prev,
    input  scd_pkg::cell_link_t  next,
    output scd_pkg::cell_link_t  own
);

    logic             valid_reg, valid_next;
    scd_pkg::sample_t value_reg, value_next;
    logic             take;

    // new sample belongs here or earlier
    assign take = !valid_reg || ($signed(ctrl.sample) < $signed(value_reg));

    assign own.valid = valid_reg;
    assign own.take  = take;
    assign own.value = value_reg;

    always_comb begin
        valid_next = valid_reg;
        value_next = value_reg;
        priority if (ctrl.ins && take) begin
            if (prev.take) begin
                valid_next = prev.valid;
                value_next = prev.value;
            end else begin
                valid_next = 1'b1;
                value_next = ctrl.sample;
            end
        end else if (ctrl.shift) begin
            valid_next = next.valid;
            value_next = next.value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        value_reg <= value_next;
    end

endmodule

`default_nettype wire

@@ sv/scd_frac.sv @@
`default_nettype none

// 2^16 / n by restoring division, then rank/n stepped by quotient and remainder.
module scd_frac (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  scd_pkg::frac_ctrl_t           ctrl,
    input  wire [scd_pkg::RANK_W-1:0]     n,
    output logic                          busy,
    output logic [scd_pkg::FRAC_W-1:0]    frac
);

    localparam int RW = scd_pkg::RANK_W;
    localparam int FW = scd_pkg::FRAC_W;
    localparam int IW = scd_pkg::DIV_IDX_W;

    logic [RW-1:0] n_reg, n_next;
    logic [IW-1:0] idx_reg, idx_next;
    logic          run_reg, run_next;
    logic          prime_reg, prime_next;
    logic [FW-1:0] quo_reg, quo_next;
    logic [RW-1:0] rdiv_reg, rdiv_next;
    logic [FW-1:0] acc_q_reg, acc_q_next;
    logic [RW-1:0] acc_r_reg, acc_r_next;

    logic [RW:0]   trial;
    logic          trial_ge;
    logic [FW-1:0] base_q;
    logic [RW-1:0] base_r;
    logic [RW:0]   rsum;
    logic          wrap;

    assign busy = run_reg || prime_reg;
    assign frac = acc_q_reg;

    // dividend is a single one at the top bit
    assign trial    = {rdiv_reg, (idx_reg == IW'(scd_pkg::DIV_MSB))};
    assign trial_ge = trial >= {1'b0, n_reg};

    assign base_q = prime_reg ? '0 : acc_q_reg;
    assign base_r = prime_reg ? (n_reg >> 1) : acc_r_reg;
    assign rsum   = {1'b0, base_r} + {1'b0, rdiv_reg};
    assign wrap   = rsum >= {1'b0, n_reg};

    always_comb begin
        n_next     = n_reg;
        idx_next   = idx_reg;
        run_next   = run_reg;
        prime_next = 1'b0;
        quo_next   = quo_reg;
        rdiv_next  = rdiv_reg;
        acc_q_next = acc_q_reg;
        acc_r_next = acc_r_reg;
        if (ctrl.start) begin
            n_next    = n;
            idx_next  = IW'(scd_pkg::DIV_MSB);
            run_next  = 1'b1;
            quo_next  = '0;
            rdiv_next = '0;
        end else if (run_reg) begin
            rdiv_next = trial_ge ? RW'(trial - {1'b0, n_reg}) : RW'(trial);
            quo_next  = {quo_reg[FW-2:0], trial_ge};
            idx_next  = idx_reg - IW'(1);
            if (idx_reg == '0) begin
                run_next   = 1'b0;
                prime_next = 1'b1;
            end
        end
        if (prime_reg || ctrl.step) begin
            acc_q_next = base_q + quo_reg + FW'(wrap);
            acc_r_next = wrap ? RW'(rsum - {1'b0, n_reg}) : RW'(rsum);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg   <= 1'b0;
            prime_reg <= 1'b0;
        end else begin
            run_reg   <= run_next;
            prime_reg <= prime_next;
        end
        n_reg     <= n_next;
        idx_reg   <= idx_next;
        quo_reg   <= quo_next;
        rdiv_reg  <= rdiv_next;
        acc_q_reg <= acc_q_next;
        acc_r_reg <= acc_r_next;
    end

endmodule

`default_nettype wire

@@ sv/scd_checker.sv @@
`default_nettype none

`include "sorted_cumulative_distribution_macros.svh"

module scd_checker (
    input wire                          aclk,
    input wire                          aresetn,
    input wire                          s_tlast,
    input wire                          s_tvalid,
    input wire                          s_tready,
    input wire [scd_pkg::M_DATA_W-1:0]  m_tdata,
    input wire [0:0]                    m_tuser,
    input wire                          m_tlast,
    input wire                          m_tvalid,
    input wire                          m_tready
);

    localparam int RLO = scd_pkg::SAMPLE_W;
    localparam int FLO = scd_pkg::SAMPLE_W + scd_pkg::RANK_W;
    localparam logic [scd_pkg::FRAC_W-1:0] FRAC_ONE = 17'h10000;

    // stalled result holds
    `SCD_ASSERT_NEXT(a_hold, m_tvalid && !m_tready,
                     m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    // largest sample always sits at fraction one
    `SCD_ASSERT_NOW(a_last_one, m_tvalid && m_tlast,
                    m_tdata[scd_pkg::M_DATA_W-1:FLO] == FRAC_ONE)

    // no result carries rank zero or a zero fraction
    `SCD_ASSERT_NOW(a_rank_frac, m_tvalid,
                    (m_tdata[FLO-1:RLO] != '0) && (m_tdata[scd_pkg::M_DATA_W-1:FLO] != '0))

    // input closes once a data set ends
    `SCD_ASSERT_NEXT(a_close, s_tvalid && s_tready && s_tlast, !s_tready)

endmodule

bind sorted_cumulative_distribution scd_checker u_scd_checker (.*);

`default_nettype wire

@@ dv/sorted_cumulative_distribution_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels, keeps its own sorted copy of each data set and
// checks every result transfer against the oldest expected point.
module scd_cdf_checker #(
    parameter int MAX_POINTS = scd_pkg::MAX_POINTS_DEF
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire  [scd_pkg::SAMPLE_W-1:0] s_tdata,
    input  wire                          s_tlast,
    input  wire                          s_tvalid,
    input  wire                          s_tready,
    input  wire  [scd_pkg::M_DATA_W-1:0] m_tdata,
    input  wire  [0:0]                   m_tuser,
    input  wire                          m_tlast,
    input  wire                          m_tvalid,
    input  wire                          m_tready,
    output int                           mismatches,
    output int                           outstanding,
    output int                           results_checked
);

    typedef struct packed {
        scd_pkg::sample_t                value;
        logic [scd_pkg::RANK_W-1:0]      rank;
        logic [scd_pkg::FRAC_W-1:0]      fraction;
        logic                            last;
        logic                            overflow;
    } cdf_point_t;

    scd_pkg::sample_t sorted_held[$];
    logic             samples_dropped = 1'b0;
    cdf_point_t       points_due[$];

    // Insert one sample in ascending order (after equal ones); on the
    // closing sample, queue one point per held sample and empty the set.
    task automatic insert_sample(input scd_pkg::sample_t v, input logic closes);
        int          pos;
        int          n;
        int          k;
        int unsigned frac;
        cdf_point_t  pt;
        if (sorted_held.size() >= MAX_POINTS) begin
            samples_dropped = 1'b1;
        end else begin
            pos = sorted_held.size();
            while (pos > 0 && v < sorted_held[pos-1])
                pos--;
            sorted_held.insert(pos, v);
        end
        if (closes) begin
            n = sorted_held.size();
            for (k = 0; k < n; k++) begin
                frac        = ((k + 1) * 65536 + n / 2) / n;
                pt.value    = sorted_held[k];
                pt.rank     = scd_pkg::RANK_W'(k + 1);
                pt.fraction = scd_pkg::FRAC_W'(frac);
                pt.last     = (k + 1 == n);
                pt.overflow = samples_dropped;
                points_due.push_back(pt);
            end
            sorted_held.delete();
            samples_dropped = 1'b0;
        end
    endtask

    task automatic report(input string field, input logic [31:0] want, input logic [31:0] got);
        $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        mismatches++;
    endtask

    always @(posedge aclk) begin
        cdf_point_t want;
        if (!aresetn) begin
            sorted_held.delete();
            points_due.delete();
            samples_dropped = 1'b0;
            outstanding <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_checked++;
                if (points_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual %h", $time,
                             {m_tuser, m_tlast, m_tdata});
                    mismatches++;
                end else begin
                    want = points_due.pop_front();
                    if (m_tdata[31:0] !== want.value)
                        report("value", want.value, m_tdata[31:0]);
                    if (m_tdata[38:32] !== want.rank)
                        report("rank", want.rank, m_tdata[38:32]);
                    if (m_tdata[55:39] !== want.fraction)
                        report("fraction", want.fraction, m_tdata[55:39]);
                    if (m_tlast !== want.last)
                        report("last_result", want.last, m_tlast);
                    if (m_tuser[0] !== want.overflow)
                        report("overflow", want.overflow, m_tuser[0]);
                end
            end
            if (s_tvalid && s_tready)
                insert_sample(s_tdata, s_tlast);
            outstanding <= points_due.size();
        end
    end

endmodule

@@ dv/sorted_cumulative_distribution_tb.sv @@
`timescale 1ns / 1ps

// Stimulus and verdict for the sorted cumulative distribution block.
// The checker beside the dut does all prediction and comparison; this
// module only feeds data sets, stalls the result channel and decides.
module sorted_cumulative_distribution_tb;

    localparam int MAX_POINTS  = scd_pkg::MAX_POINTS_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN       = 64;       // divider set-up plus margin

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic [scd_pkg::SAMPLE_W-1:0]  s_tdata  = '0;
    logic                          s_tlast  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [scd_pkg::M_DATA_W-1:0]  m_tdata;
    logic [0:0]                    m_tuser;
    logic                          m_tlast;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;

    int mismatches;
    int outstanding;
    int results_checked;

    // Idle chances in percent, changed between phases
    int send_idle = 28;
    int recv_idle = 77;

    int cycle_count    = 0;
    int samples_sent   = 0;
    int sets_sent      = 0;
    int sets_overflown = 0;

    always begin
        aclk = 1'b0;
        #10;
        aclk = 1'b1;
        #10;
    end

    sorted_cumulative_distribution #(
        .MAX_POINTS (MAX_POINTS)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    scd_cdf_checker #(
        .MAX_POINTS (MAX_POINTS)
    ) checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .mismatches      (mismatches),
        .outstanding     (outstanding),
        .results_checked (results_checked)
    );

    // Receiver: a fresh stall decision every cycle, so stalls land on the
    // first, middle and last result of a set alike.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= recv_idle);
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // Watchdog: only reached if the run hangs
    initial begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge aclk);
        $display("Timed out after %0d cycles with %0d results still due", cycle_count,
                 outstanding);
        $display("** sorted_cumulative_distribution: FAILED **");
        $finish;
    end

    // One sample transfer. A random gap may precede it; tvalid is only
    // lowered in cycles where no new item is offered. Because the dut
    // updates on the same edge, s_tready read just after the edge is the
    // value that edge saw, so the loop leaves on the accepting edge.
    task automatic push_sample(input logic [31:0] value, input logic closes);
        while ($urandom_range(0, 99) < send_idle) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= value;
        s_tlast  <= closes;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        samples_sent++;
    endtask

    // Hold the sender off until the checker has seen every result due.
    // The first edge lets the checker's count catch up with the last transfer.
    task automatic wait_for_results;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
    endtask

    task automatic send_set(input logic [31:0] values[$]);
        for (int i = 0; i < values.size(); i++)
            push_sample(values[i], i == values.size() - 1);
        sets_sent++;
        if (values.size() > MAX_POINTS)
            sets_overflown++;
    endtask

    // Mix of extremes, a narrow band that gives many equal samples, and
    // full-range values so every data bit toggles.
    function automatic logic [31:0] pick_sample;
        int unsigned r;
        r = $urandom_range(0, 9);
        case (r)
            0:       pick_sample = 32'h8000_0000;
            1:       pick_sample = 32'h7fff_ffff;
            2, 3, 4: pick_sample = 32'($signed($urandom_range(0, 8)) - 4);
            default: pick_sample = $urandom;
        endcase
    endfunction

    initial begin
        logic [31:0] set_values[$];
        int          set_size;
        logic        big_sent;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed sets
        // lone minimum, lone maximum
        set_values = '{32'h8000_0000};
        send_set(set_values);
        set_values = '{32'h7fff_ffff};
        send_set(set_values);
        // reversed pair, which a broken insertion leaves unsorted
        set_values = '{32'h0002_0000, 32'h0001_0000};
        send_set(set_values);
        // both extremes with zero and the values either side of it
        set_values = '{32'h7fff_ffff, 32'h0000_0000, 32'h8000_0000, 32'hffff_ffff,
                       32'h0000_0001};
        send_set(set_values);
        // all samples equal
        set_values = '{32'h0005_0000, 32'h0005_0000, 32'h0005_0000};
        send_set(set_values);
        // duplicates of both signs
        set_values = '{32'h0000_0003, 32'hffff_fffd, 32'h0000_0003, 32'hffff_fffd,
                       32'h0000_0000, 32'h0000_0007};
        send_set(set_values);
        // already ascending
        set_values = '{32'h0000_0001, 32'h0000_0002, 32'h0000_0003, 32'h0000_0004};
        send_set(set_values);
        wait_for_results();

        // Random sets: mostly short, and one that fills the store and
        // overflows it (dropping its closing sample as well).
        big_sent = 1'b0;
        while (samples_sent < 120) begin
            if (samples_sent < 40) begin
                send_idle = 28;
                recv_idle = 77;
            end else if (samples_sent < 60) begin
                send_idle = 77;
                recv_idle = 28;
            end else begin
                send_idle = 0;
                recv_idle = 0;
            end
            if (!big_sent && samples_sent >= 60) begin
                set_size = MAX_POINTS + 1;
                big_sent = 1'b1;
            end else if ($urandom_range(0, 99) < 75) begin
                set_size = $urandom_range(1, 6);
            end else begin
                set_size = $urandom_range(7, 12);
            end
            set_values.delete();
            repeat (set_size) set_values.push_back(pick_sample());
            send_set(set_values);
            if ($urandom_range(0, 3) == 0)
                wait_for_results();
        end

        // Drain: all results in, then a quiet spell to catch strays
        wait_for_results();
        repeat (DRAIN) @(posedge aclk);

        $display("Sent %0d samples in %0d data sets (%0d overflowing the store);",
                 samples_sent, sets_sent, sets_overflown);
        $display("checked %0d results under three stall patterns.", results_checked);
        if (mismatches == 0 && outstanding == 0) begin
            $display("** sorted_cumulative_distribution: PASSED **");
        end else begin
            $display("%0d mismatches, %0d results never arrived", mismatches, outstanding);
            $display("** sorted_cumulative_distribution: FAILED **");
        end
        $finish;
    end

endmodule
